/* sv/linear_probe_hash_table_assert.svh */
// ----------------------------------------------------------------------------
// linear_probe_hash_table assertion macros
// shared property forms for the hash table checker
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LPHT_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hash table check failed");

// next-cycle implication, disabled during reset
`define LPHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hash table check failed");

`endif

/* sv/lpht_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_pkg
// shared constants, codes and helpers of the linear probe hash table
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int SLOTS_DEF   = 256;
    localparam int KEY_CHARS   = 8;
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 4;
    localparam int VAL_W       = 32;
    localparam int CAP_W       = 9;
    localparam int KIND_W      = 3;
    localparam int STAT_W      = 3;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 9;
    localparam int HASH_W      = 64;
    localparam int MOD_BITS    = 4;
    localparam int ENT_W       = KEY_W + LEN_W + VAL_W;
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 120;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    // operation kinds
    localparam logic [KIND_W-1:0] K_INSERT = 3'd0;
    localparam logic [KIND_W-1:0] K_ERASE  = 3'd1;
    localparam logic [KIND_W-1:0] K_SEARCH = 3'd2;
    localparam logic [KIND_W-1:0] K_FIRST  = 3'd3;
    localparam logic [KIND_W-1:0] K_NEXT   = 3'd4;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] ST_ERASED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd5;
    localparam logic [STAT_W-1:0] ST_END      = 3'd6;

    // slot marks
    localparam logic [1:0] MARK_EMPTY = 2'd0;
    localparam logic [1:0] MARK_LIVE  = 2'd1;
    localparam logic [1:0] MARK_TOMB  = 2'd2;

    // ascii upper to lower, other codes unchanged
    function automatic logic [7:0] lower_char(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5a) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

/* sv/linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// open-addressing key/value store with linear probing and an ordered scan
// ----------------------------------------------------------------------------
// Requests enter on s_axis: tuser is the kind (insert, erase, search, first,
// next), tdata carries key characters, key length and value. Each request
// gives exactly one result on m_axis: tuser is the status, tdata the entry
// returned, slot index and live entry count. i_cfg_we writes the capacity.
// One request is worked at a time. Insert, erase and search hash the key,
// one cycle per key character, then take the 4-bit-per-cycle remainder by
// the capacity, then probe slot by slot; each probe is a registered read of
// the slot memories followed by a check of the slot read. First and next
// scan the slots in order, each visit a registered read and a check.
// After reset the mark memory is swept to empty, one slot per cycle;
// s_axis_tready stays low meanwhile, capacity writes are taken.
// The result sits in an output register; a stalled receiver holds the
// finished request there and the next request may already be accepted, but
// it waits at its end until the register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table #(
    parameter int SLOTS = lpht_pkg::SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpht_pkg::CAP_W-1:0]          i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // key_chars[63:0], key_length[67:64], value[99:68], zero fill
    input  logic [lpht_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // kind[2:0]
    input  logic [lpht_pkg::KIND_W-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // found_key[63:0], found_key_length[67:64], found_value[99:68],
    // slot_index[107:100], entry_count[116:108], zero fill
    output logic [lpht_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // status[2:0]
    output logic [lpht_pkg::STAT_W-1:0]         m_axis_tuser
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_HASH  = 9'b000000100,
        S_MOD   = 9'b000001000,
        S_PRD   = 9'b000010000,
        S_PCHK  = 9'b000100000,
        S_SRD   = 9'b001000000,
        S_SCHK  = 9'b010000000,
        S_RES   = 9'b100000000
    } t_state;

    t_state r_state, n_state;

    // slot memories
    logic [1:0]                  mark_mem [SLOTS];
    logic [lpht_pkg::ENT_W-1:0]  ent_mem  [SLOTS];
    logic [1:0]                  r_mark_rd;
    logic [lpht_pkg::ENT_W-1:0]  r_ent_rd;

    logic [lpht_pkg::CAP_W-1:0]  r_cap;
    logic [IW-1:0]               r_clr;
    logic [lpht_pkg::KIND_W-1:0] r_kind;
    logic [lpht_pkg::KEY_W-1:0]  r_raw;
    logic [lpht_pkg::LEN_W-1:0]  r_len_eff;
    logic [lpht_pkg::VAL_W-1:0]  r_val;
    logic [lpht_pkg::KEY_W-1:0]  r_key;
    logic [lpht_pkg::LEN_W-1:0]  r_n;
    logic [lpht_pkg::LEN_W-1:0]  r_i;
    logic [lpht_pkg::HASH_W-1:0] r_h;
    logic [3:0]                  r_mc;
    logic [CW-1:0]               r_rem;
    logic [IW-1:0]               r_pos;
    logic [CW-1:0]               r_k;
    logic [IW-1:0]               r_free;
    logic                        r_have_free;
    logic                        r_hit;
    logic [lpht_pkg::KEY_W-1:0]  r_ekey;
    logic [lpht_pkg::LEN_W-1:0]  r_elen;
    logic [lpht_pkg::VAL_W-1:0]  r_eval;
    logic [lpht_pkg::CNT_W-1:0]  r_cnt;
    logic [IW-1:0]               r_cur;
    logic                        r_cur_v;

    logic                        r_o_valid;
    logic [lpht_pkg::STAT_W-1:0] r_o_status;
    logic [lpht_pkg::KEY_W-1:0]  r_o_key;
    logic [lpht_pkg::LEN_W-1:0]  r_o_len;
    logic [lpht_pkg::VAL_W-1:0]  r_o_val;
    logic [lpht_pkg::SLOT_W-1:0] r_o_slot;
    logic [lpht_pkg::CNT_W-1:0]  r_o_cnt;

    logic [31:0]                 w_cap32;
    logic [CW-1:0]               w_cap;
    logic                        w_accept;
    logic [7:0]                  w_c;
    logic                        w_hash_end;
    logic [lpht_pkg::HASH_W-1:0] w_h_next;
    logic [CW-1:0]               w_rem_next;
    logic [CW:0]                 w_t;
    logic [lpht_pkg::LEN_W-1:0]  w_in_len;
    logic                        w_match;
    logic                        w_last_probe;
    logic [IW-1:0]               w_pos_inc;
    logic                        w_fire;
    logic [lpht_pkg::STAT_W-1:0] w_st;
    logic                        w_show;
    logic [IW-1:0]               w_slot;
    logic [31:0]                 w_slot32;
    logic [lpht_pkg::CNT_W-1:0]  w_cnt_next;
    logic                        w_ent_we;
    logic                        w_mark_we;
    logic [IW-1:0]               w_mark_wa;
    logic [1:0]                  w_mark_wd;
    logic                        w_rd_en;
    logic [IW-1:0]               w_rd_addr;
    logic                        w_cur_set;
    logic                        w_cur_clr;

    // effective capacity, clamped to 1..SLOTS
    always_comb begin
        if (r_cap == '0) begin
            w_cap32 = 32'd1;
        end else if (32'(r_cap) > 32'(SLOTS)) begin
            w_cap32 = 32'(SLOTS);
        end else begin
            w_cap32 = 32'(r_cap);
        end
        w_cap = w_cap32[CW-1:0];
    end

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_in_len = (s_axis_tdata[67:64] > 4'(lpht_pkg::KEY_CHARS))
                    ? 4'(lpht_pkg::KEY_CHARS) : s_axis_tdata[67:64];

    // hash step, one character per cycle
    assign w_c        = r_raw[8*r_i[2:0] +: 8];
    assign w_hash_end = (r_i == r_len_eff) || (w_c == 8'd0);
    assign w_h_next   = (r_h << 5) + r_h + 64'(lpht_pkg::lower_char(w_c));

    // remainder step, four dividend bits per cycle
    always_comb begin
        w_rem_next = r_rem;
        w_t        = '0;
        for (int j = 0; j < lpht_pkg::MOD_BITS; j++) begin
            w_t = {w_rem_next, r_h[lpht_pkg::HASH_W-1-j]};
            if (w_t >= {1'b0, w_cap}) begin
                w_rem_next = CW'(w_t - {1'b0, w_cap});
            end else begin
                w_rem_next = w_t[CW-1:0];
            end
        end
    end

    // probe compare and advance
    assign w_match = (r_ent_rd[lpht_pkg::VAL_W +: lpht_pkg::LEN_W] == r_n)
                  && (r_ent_rd[lpht_pkg::VAL_W + lpht_pkg::LEN_W +: lpht_pkg::KEY_W] == r_key);
    assign w_last_probe = (32'(r_k) + 32'd1 == w_cap32);
    assign w_pos_inc    = (32'(r_pos) + 32'd1 == w_cap32) ? '0 : r_pos + 1'b1;

    // result decode
    assign w_fire = (r_state == S_RES) && (!r_o_valid || m_axis_tready);

    always_comb begin
        w_st       = lpht_pkg::ST_NOTFOUND;
        w_show     = 1'b0;
        w_slot     = r_pos;
        w_cnt_next = r_cnt;
        w_ent_we   = 1'b0;
        w_cur_set  = 1'b0;
        w_cur_clr  = 1'b0;
        unique case (r_kind)
            lpht_pkg::K_INSERT: begin
                if (r_hit) begin
                    w_st     = lpht_pkg::ST_UPDATED;
                    w_ent_we = 1'b1;
                end else if (r_have_free) begin
                    w_st       = lpht_pkg::ST_INSERTED;
                    w_slot     = r_free;
                    w_ent_we   = 1'b1;
                    w_cnt_next = r_cnt + 1'b1;
                    w_cur_set  = 1'b1;
                end else begin
                    w_st = lpht_pkg::ST_FULL;
                end
            end
            lpht_pkg::K_ERASE: begin
                if (r_hit) begin
                    w_st       = lpht_pkg::ST_ERASED;
                    w_cnt_next = r_cnt - 1'b1;
                end
            end
            lpht_pkg::K_SEARCH, lpht_pkg::K_FIRST, lpht_pkg::K_NEXT: begin
                if (r_hit) begin
                    w_st      = lpht_pkg::ST_FOUND;
                    w_show    = 1'b1;
                    w_cur_set = 1'b1;
                end else begin
                    w_st      = (r_kind == lpht_pkg::K_SEARCH)
                              ? lpht_pkg::ST_NOTFOUND : lpht_pkg::ST_END;
                    w_cur_clr = 1'b1;
                end
            end
            default: begin
                w_st = lpht_pkg::ST_NOTFOUND;
            end
        endcase
    end

    assign w_slot32 = 32'(w_slot);

    // mark write port: clearing sweep or commit
    always_comb begin
        w_mark_we = 1'b0;
        w_mark_wa = r_pos;
        w_mark_wd = lpht_pkg::MARK_EMPTY;
        if (r_state == S_CLEAR) begin
            w_mark_we = 1'b1;
            w_mark_wa = r_clr;
        end else if (w_fire && r_kind == lpht_pkg::K_INSERT && !r_hit && r_have_free) begin
            w_mark_we = 1'b1;
            w_mark_wa = r_free;
            w_mark_wd = lpht_pkg::MARK_LIVE;
        end else if (w_fire && r_kind == lpht_pkg::K_ERASE && r_hit) begin
            w_mark_we = 1'b1;
            w_mark_wd = lpht_pkg::MARK_TOMB;
        end
    end

    assign w_rd_en   = (r_state == S_PRD) || (r_state == S_SRD);
    assign w_rd_addr = (r_state == S_PRD) ? r_pos : r_k[IW-1:0];

    // slot memories, registered read
    always_ff @(posedge i_clk) begin
        if (w_mark_we) begin
            mark_mem[w_mark_wa] <= w_mark_wd;
        end
        if (w_fire && w_ent_we) begin
            ent_mem[w_slot] <= {r_key, r_n, r_val};
        end
        if (w_rd_en) begin
            r_mark_rd <= mark_mem[w_rd_addr];
            r_ent_rd  <= ent_mem[w_rd_addr];
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (32'(r_clr) == 32'(SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    case (s_axis_tuser) inside
                        lpht_pkg::K_INSERT, lpht_pkg::K_ERASE, lpht_pkg::K_SEARCH:
                            n_state = S_HASH;
                        lpht_pkg::K_FIRST:
                            n_state = S_SRD;
                        lpht_pkg::K_NEXT:
                            n_state = r_cur_v ? S_SRD : S_RES;
                        default:
                            n_state = S_RES;
                    endcase
                end
            end
            S_HASH: begin
                if (w_hash_end) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (r_mc == 4'hf) begin
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if ((r_mark_rd == lpht_pkg::MARK_LIVE && w_match)
                        || r_mark_rd == lpht_pkg::MARK_EMPTY || w_last_probe) begin
                    n_state = S_RES;
                end else begin
                    n_state = S_PRD;
                end
            end
            S_SRD: begin
                n_state = (32'(r_k) >= w_cap32) ? S_RES : S_SCHK;
            end
            S_SCHK: begin
                n_state = (r_mark_rd == lpht_pkg::MARK_LIVE) ? S_RES : S_SRD;
            end
            S_RES: begin
                if (w_fire) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr     <= '0;
            r_cap     <= lpht_pkg::CAP_RESET;
            r_cnt     <= '0;
            r_cur     <= '0;
            r_cur_v   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end

            // clearing sweep
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            // request capture
            if (w_accept) begin
                r_kind      <= s_axis_tuser;
                r_raw       <= s_axis_tdata[63:0];
                r_len_eff   <= w_in_len;
                r_val       <= s_axis_tdata[99:68];
                r_key       <= '0;
                r_n         <= '0;
                r_i         <= '0;
                r_h         <= '0;
                r_hit       <= 1'b0;
                r_have_free <= 1'b0;
                r_k         <= (s_axis_tuser == lpht_pkg::K_NEXT)
                             ? CW'(32'(r_cur) + 32'd1) : '0;
            end

            // hash over the key characters
            if (r_state == S_HASH) begin
                if (w_hash_end) begin
                    r_mc  <= '0;
                    r_rem <= '0;
                end else begin
                    r_key[8*r_i[2:0] +: 8] <= w_c;
                    r_h <= w_h_next;
                    r_n <= r_n + 1'b1;
                    r_i <= r_i + 1'b1;
                end
            end

            // remainder by the capacity
            if (r_state == S_MOD) begin
                r_rem <= w_rem_next;
                r_h   <= r_h << lpht_pkg::MOD_BITS;
                r_mc  <= r_mc + 1'b1;
                if (r_mc == 4'hf) begin
                    r_pos <= w_rem_next[IW-1:0];
                    r_k   <= '0;
                end
            end

            // probe walk
            if (r_state == S_PCHK) begin
                if (r_mark_rd == lpht_pkg::MARK_LIVE && w_match) begin
                    r_hit  <= 1'b1;
                    r_ekey <= r_ent_rd[lpht_pkg::VAL_W + lpht_pkg::LEN_W +: lpht_pkg::KEY_W];
                    r_elen <= r_ent_rd[lpht_pkg::VAL_W +: lpht_pkg::LEN_W];
                    r_eval <= r_ent_rd[lpht_pkg::VAL_W-1:0];
                end else begin
                    if (r_mark_rd != lpht_pkg::MARK_LIVE && !r_have_free) begin
                        r_free      <= r_pos;
                        r_have_free <= 1'b1;
                    end
                    r_pos <= w_pos_inc;
                    r_k   <= r_k + 1'b1;
                end
            end

            // ordered scan
            if (r_state == S_SCHK) begin
                if (r_mark_rd == lpht_pkg::MARK_LIVE) begin
                    r_hit  <= 1'b1;
                    r_pos  <= r_k[IW-1:0];
                    r_ekey <= r_ent_rd[lpht_pkg::VAL_W + lpht_pkg::LEN_W +: lpht_pkg::KEY_W];
                    r_elen <= r_ent_rd[lpht_pkg::VAL_W +: lpht_pkg::LEN_W];
                    r_eval <= r_ent_rd[lpht_pkg::VAL_W-1:0];
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end

            // commit and result register
            if (w_fire) begin
                r_cnt      <= w_cnt_next;
                r_o_valid  <= 1'b1;
                r_o_status <= w_st;
                r_o_key    <= w_show ? r_ekey : '0;
                r_o_len    <= w_show ? r_elen : '0;
                r_o_val    <= w_show ? r_eval : '0;
                r_o_slot   <= (w_st == lpht_pkg::ST_NOTFOUND || w_st == lpht_pkg::ST_FULL
                               || w_st == lpht_pkg::ST_END) ? '0 : w_slot32[7:0];
                r_o_cnt    <= w_cnt_next;
                if (w_cur_set) begin
                    r_cur   <= w_slot;
                    r_cur_v <= 1'b1;
                end else if (w_cur_clr) begin
                    r_cur_v <= 1'b0;
                end
            end else if (m_axis_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = r_o_status;
    assign m_axis_tdata  = {3'b000, r_o_cnt, r_o_slot, r_o_val, r_o_len, r_o_key};

endmodule

/* sv/lpht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// port-level checks on the hash table result stream
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_assert.svh"

module lpht_port_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [lpht_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [lpht_pkg::STAT_W-1:0]      m_axis_tuser
);

    // stalled result holds
    `LPHT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // entry fields only come with a found status
    `LPHT_ASSERT_IMPLY(a_entry_zero, m_axis_tvalid && m_axis_tuser != lpht_pkg::ST_FOUND, m_axis_tdata[99:0] == '0)

    // no slot reported when nothing was touched
    `LPHT_ASSERT_IMPLY(a_slot_zero, m_axis_tvalid && (m_axis_tuser == lpht_pkg::ST_NOTFOUND || m_axis_tuser == lpht_pkg::ST_FULL || m_axis_tuser == lpht_pkg::ST_END), m_axis_tdata[107:100] == '0)

    // an insert leaves at least one live entry
    `LPHT_ASSERT_IMPLY(a_insert_count, m_axis_tvalid && m_axis_tuser == lpht_pkg::ST_INSERTED, m_axis_tdata[116:108] != '0)

endmodule

bind linear_probe_hash_table lpht_port_checker u_lpht_port_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

/* tb/lpht_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpht_checker
// watches the request and result streams of the hash table, keeps its own
// copy of the slot store, predicts every result and compares field by field
// ----------------------------------------------------------------------------
module lpht_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lpht_pkg::CAP_W-1:0]          i_cfg_wdata,
    input  logic                                i_req_valid,
    input  logic                                i_req_ready,
    // key_chars[63:0], key_length[67:64], value[99:68], zero fill
    input  logic [lpht_pkg::IN_TDATA_W-1:0]     i_req_data,
    // kind[2:0]
    input  logic [lpht_pkg::KIND_W-1:0]         i_req_kind,
    input  logic                                i_res_valid,
    input  logic                                i_res_ready,
    // found_key[63:0], found_key_length[67:64], found_value[99:68],
    // slot_index[107:100], entry_count[116:108], zero fill
    input  logic [lpht_pkg::OUT_TDATA_W-1:0]    i_res_data,
    // status[2:0]
    input  logic [lpht_pkg::STAT_W-1:0]         i_res_status,
    output int                                  o_fail_count,
    output int                                  o_result_count
);
    import lpht_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_len;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
        logic [CNT_W-1:0]  count;
    } t_table_result;

    // model copy of the table
    logic [KEY_W-1:0]  mdl_key   [SLOTS_DEF];
    logic [LEN_W-1:0]  mdl_len   [SLOTS_DEF];
    logic [VAL_W-1:0]  mdl_value [SLOTS_DEF];
    logic [1:0]        mdl_mark  [SLOTS_DEF];
    logic [CAP_W-1:0]  mdl_cap;
    int                mdl_live;
    int                mdl_cursor;
    bit                mdl_cursor_ok;

    t_table_result     pending_results[$];

    // work out one request's result and update the model table
    task automatic apply_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] raw,
                                 input logic [LEN_W-1:0] len_in, input logic [VAL_W-1:0] val,
                                 output t_table_result r);
        int cap, ln, n, i, pos, k, free_slot;
        bit have_free, done;
        logic [63:0] key, h;
        logic [7:0] c;
        cap = (mdl_cap == 0) ? 1 : (mdl_cap > SLOTS_DEF) ? SLOTS_DEF : int'(mdl_cap);
        ln = (len_in > KEY_CHARS) ? KEY_CHARS : int'(len_in);
        key = '0;
        h = '0;
        n = 0;
        have_free = 0;
        free_slot = 0;
        done = 0;
        r = '0;
        for (i = 0; i < ln; i++) begin
            c = raw[8*i +: 8];
            if (c == 8'd0) break;
            key[8*i +: 8] = c;
            if (c >= "A" && c <= "Z") c = c + 8'd32;
            h = (h << 5) + h + {56'd0, c};
            n++;
        end
        pos = int'(h % 64'(cap));
        if (kind == K_INSERT || kind == K_ERASE || kind == K_SEARCH) begin
            for (k = 0; k < cap; k++) begin
                if (mdl_mark[pos] == MARK_EMPTY) begin
                    if (!have_free) begin
                        free_slot = pos;
                        have_free = 1;
                    end
                    break;
                end
                if (mdl_mark[pos] == MARK_TOMB) begin
                    if (!have_free) begin
                        free_slot = pos;
                        have_free = 1;
                    end
                end else if (mdl_len[pos] == n && mdl_key[pos] == key) begin
                    done = 1;
                    r.slot = pos[7:0];
                    if (kind == K_INSERT) begin
                        mdl_value[pos] = val;
                        r.status = ST_UPDATED;
                    end else if (kind == K_ERASE) begin
                        mdl_mark[pos] = MARK_TOMB;
                        mdl_live--;
                        r.status = ST_ERASED;
                    end else begin
                        mdl_cursor = pos;
                        mdl_cursor_ok = 1;
                        r.status = ST_FOUND;
                        r.key = mdl_key[pos];
                        r.key_len = mdl_len[pos];
                        r.value = mdl_value[pos];
                    end
                    break;
                end
                pos = (pos + 1 == cap) ? 0 : pos + 1;
            end
            if (!done) begin
                if (kind == K_INSERT) begin
                    if (!have_free) begin
                        r.status = ST_FULL;
                    end else begin
                        mdl_key[free_slot] = key;
                        mdl_len[free_slot] = n[3:0];
                        mdl_value[free_slot] = val;
                        mdl_mark[free_slot] = MARK_LIVE;
                        mdl_live++;
                        mdl_cursor = free_slot;
                        mdl_cursor_ok = 1;
                        r.status = ST_INSERTED;
                        r.slot = free_slot[7:0];
                    end
                end else begin
                    if (kind == K_SEARCH) mdl_cursor_ok = 0;
                    r.status = ST_NOTFOUND;
                end
            end
        end else if (kind == K_FIRST || kind == K_NEXT) begin
            r.status = ST_END;
            if (kind == K_FIRST || mdl_cursor_ok) begin
                for (k = (kind == K_FIRST) ? 0 : mdl_cursor + 1; k < cap; k++) begin
                    if (mdl_mark[k] == MARK_LIVE) begin
                        done = 1;
                        mdl_cursor = k;
                        mdl_cursor_ok = 1;
                        r.status = ST_FOUND;
                        r.key = mdl_key[k];
                        r.key_len = mdl_len[k];
                        r.value = mdl_value[k];
                        r.slot = k[7:0];
                        break;
                    end
                end
                if (!done) mdl_cursor_ok = 0;
            end
        end else begin
            r.status = ST_NOTFOUND;
        end
        r.count = mdl_live[8:0];
    endtask

    // predict on each request, compare on each result
    always @(posedge i_clk) begin
        t_table_result exp_r, got_r;
        if (!i_rst_n) begin
            for (int s = 0; s < SLOTS_DEF; s++) mdl_mark[s] = MARK_EMPTY;
            mdl_cap = CAP_RESET;
            mdl_live = 0;
            mdl_cursor = 0;
            mdl_cursor_ok = 0;
            pending_results.delete();
            o_fail_count = 0;
            o_result_count = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                o_result_count++;
                got_r.status = i_res_status;
                got_r.key = i_res_data[63:0];
                got_r.key_len = i_res_data[67:64];
                got_r.value = i_res_data[99:68];
                got_r.slot = i_res_data[107:100];
                got_r.count = i_res_data[116:108];
                if (pending_results.size() == 0) begin
                    $error("result with no request waiting, status %0d", got_r.status);
                    o_fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    if (got_r.status !== exp_r.status) begin
                        $error("status expected %0d got %0d", exp_r.status, got_r.status);
                        o_fail_count++;
                    end
                    if (got_r.key !== exp_r.key) begin
                        $error("found_key expected %h got %h", exp_r.key, got_r.key);
                        o_fail_count++;
                    end
                    if (got_r.key_len !== exp_r.key_len) begin
                        $error("found_key_length expected %0d got %0d",
                               exp_r.key_len, got_r.key_len);
                        o_fail_count++;
                    end
                    if (got_r.value !== exp_r.value) begin
                        $error("found_value expected %h got %h", exp_r.value, got_r.value);
                        o_fail_count++;
                    end
                    if (got_r.slot !== exp_r.slot) begin
                        $error("slot_index expected %0d got %0d", exp_r.slot, got_r.slot);
                        o_fail_count++;
                    end
                    if (got_r.count !== exp_r.count) begin
                        $error("entry_count expected %0d got %0d", exp_r.count, got_r.count);
                        o_fail_count++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                apply_request(i_req_kind, i_req_data[63:0], i_req_data[67:64],
                              i_req_data[99:68], exp_r);
                pending_results.push_back(exp_r);
            end
            if (i_cfg_we) mdl_cap = i_cfg_wdata;
        end
    end

endmodule

/* tb/tb_linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// drives insert, erase, search and scan requests through several capacity
// settings with random idling on both streams; the checker predicts results
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;
    import lpht_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;
    localparam int PHASE_ITEMS = 72;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CAP_W-1:0]         i_cfg_wdata = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata = '0;
    logic [KIND_W-1:0]        s_axis_tuser = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic [STAT_W-1:0]        m_axis_tuser;

    int fail_count, result_count;
    int requests_sent = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    bit idle_on = 1'b1;

    logic [KEY_W-1:0] key_pool [16];
    logic [LEN_W-1:0] len_pool [16];

    always #5 i_clk = ~i_clk;

    linear_probe_hash_table u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    lpht_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_req_valid(s_axis_tvalid), .i_req_ready(s_axis_tready),
        .i_req_data(s_axis_tdata), .i_req_kind(s_axis_tuser),
        .i_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_res_data(m_axis_tdata), .i_res_status(m_axis_tuser),
        .o_fail_count(fail_count), .o_result_count(result_count)
    );

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off when asked
    initial begin
        int gap;
        @(posedge i_clk);
        forever begin
            gap = idle_on ? $urandom_range(0, 3) : 0;
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // offer one request and wait for it to be taken
    task automatic send_request(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] chars,
                                input logic [LEN_W-1:0] len, input logic [VAL_W-1:0] val);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= kind;
        s_axis_tdata <= {4'd0, val, len, chars};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        requests_sent++;
    endtask

    // drain all results, then let the block settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (result_count != requests_sent);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= cap;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // random request: mostly pool keys so probes collide, some raw noise
    task automatic send_random();
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  chars;
        logic [LEN_W-1:0]  len;
        int pick, sel;
        pick = $urandom_range(0, 99);
        if (pick < 36) kind = K_INSERT;
        else if (pick < 52) kind = K_ERASE;
        else if (pick < 76) kind = K_SEARCH;
        else if (pick < 83) kind = K_FIRST;
        else if (pick < 97) kind = K_NEXT;
        else kind = KIND_W'($urandom_range(5, 7));
        sel = $urandom_range(0, 15);
        chars = key_pool[sel];
        len = len_pool[sel];
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            chars = {$urandom, $urandom};
            len = LEN_W'($urandom_range(0, 15));
        end else if (pick == 1) begin
            // junk past the end of the key
            chars = chars | ({$urandom, $urandom} << (8 * len));
            if (len >= KEY_CHARS) len = LEN_W'($urandom_range(8, 15));
        end
        send_request(kind, chars, len, $urandom);
    endtask

    initial begin
        logic [CAP_W-1:0] caps [11];
        int p;
        caps = '{9'd256, 9'd1, 9'd0, 9'd2, 9'd5, 9'd511, 9'd300, 9'd16, 9'd3, 9'd64, 9'd256};
        // pool: letters and case twins that share a home slot
        for (int i = 0; i < 16; i++) begin
            len_pool[i] = LEN_W'($urandom_range(1, 8));
            key_pool[i] = '0;
            for (int j = 0; j < len_pool[i]; j++)
                key_pool[i][8*j +: 8] = 8'($urandom_range(8'h61, 8'h7a));
        end
        for (int i = 8; i < 12; i++) begin
            key_pool[i] = key_pool[i-8] & 64'hdfdf_dfdf_dfdf_dfdf;
            len_pool[i] = len_pool[i-8];
        end
        key_pool[12] = 64'hffff_ffff_ffff_ffff;
        len_pool[12] = 4'd8;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_capacity(CAP_RESET);

        // directed part
        send_request(K_INSERT, 64'h61, 4'd1, 32'h0);
        send_request(K_INSERT, 64'h41, 4'd1, 32'hffff_ffff);
        send_request(K_INSERT, 64'h61, 4'd1, 32'h1234_5678);
        send_request(K_SEARCH, 64'h61, 4'd1, 32'h0);
        send_request(K_SEARCH, 64'h41, 4'd1, 32'h0);
        send_request(K_FIRST, 64'h0, 4'd0, 32'h0);
        send_request(K_NEXT, 64'h0, 4'd0, 32'h0);
        send_request(K_NEXT, 64'h0, 4'd0, 32'h0);
        send_request(K_ERASE, 64'h61, 4'd1, 32'h0);
        send_request(K_SEARCH, 64'h41, 4'd1, 32'h0);
        send_request(K_ERASE, 64'h7a7a, 4'd2, 32'h0);
        send_request(K_INSERT, 64'h61, 4'd1, 32'h5555_aaaa);
        send_request(K_INSERT, 64'hffff_ffff_ffff_ffff, 4'd0, 32'h1);
        send_request(K_INSERT, 64'hffff_ffff_ffff_ffff, 4'd15, 32'h2);
        send_request(K_INSERT, 64'h6363_0062, 4'd4, 32'h3);
        send_request(K_SEARCH, 64'h62, 4'd1, 32'h0);
        send_request(K_SEARCH, 64'h7171, 4'd2, 32'h0);
        send_request(K_NEXT, 64'h0, 4'd0, 32'h0);
        send_request(3'd5, 64'h61, 4'd1, 32'h0);
        send_request(3'd6, 64'h61, 4'd1, 32'h0);
        send_request(3'd7, 64'h61, 4'd1, 32'h0);
        wait_idle();

        // capacity sweep: small tables fill up and wrap, large ones stay sparse
        for (p = 0; p < 11; p++) begin
            write_capacity(caps[p]);
            idle_on = (p % 4) != 2;
            if (p == 5) hold_cycles = 600;
            if (p == 3) begin
                for (int i = 0; i < 4; i++) send_request(K_INSERT, key_pool[i], len_pool[i], i);
                send_request(K_SEARCH, key_pool[5], len_pool[5], 32'h0);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) send_random();
            wait_idle();
        end

        $display("covered %0d requests over %0d capacity settings", requests_sent, 11);
        $display("including full tables, tombstone reuse and scans past the capacity");
        if (fail_count == 0 && result_count == requests_sent) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
